// ===== rtl/gbs_pkg.sv =====
// Shared types and fixed widths for the greedy box suppression block.
// No dependencies; used by the channel interfaces and all RTL modules.
package gbs_pkg;

   localparam int COORD_W = 12;
   localparam int SIZE_W  = 11;
   localparam int AREA_W  = 2 * SIZE_W;
   localparam int THR_W   = 9;
   localparam int INDEX_W = 10;

   localparam logic [THR_W-1:0] THR_RESET = 9'd115;

   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic        [SIZE_W-1:0]  width;
      logic        [SIZE_W-1:0]  height;
   } box_type;

   typedef struct packed {
      box_type           box;
      logic [AREA_W-1:0] area;
   } entry_type;

   typedef struct packed {
      logic busy;
      logic hit;
   } cmp_type;

endpackage

// ===== rtl/gbs_req_if.sv =====
// Input channel carrying one detection box per beat.
// Depends on gbs_pkg for field widths.
interface gbs_req_if;
   logic                                valid;
   logic                                ready;
   logic                                first_of_set;
   logic signed [gbs_pkg::COORD_W-1:0] box_left;
   logic signed [gbs_pkg::COORD_W-1:0] box_top;
   logic        [gbs_pkg::SIZE_W-1:0]  box_width;
   logic        [gbs_pkg::SIZE_W-1:0]  box_height;

   modport source (output valid, first_of_set, box_left, box_top, box_width, box_height,
                   input ready);
   modport sink (input valid, first_of_set, box_left, box_top, box_width, box_height,
                 output ready);
endinterface

// ===== rtl/gbs_rsp_if.sv =====
// Result channel carrying the keep or drop verdict for one box per beat.
// Depends on gbs_pkg for field widths.
interface gbs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          kept;
   logic [gbs_pkg::INDEX_W-1:0]   box_index;
   logic                          store_overflow;

   modport source (output valid, kept, box_index, store_overflow, input ready);
   modport sink (input valid, kept, box_index, store_overflow, output ready);
endinterface

// ===== rtl/gbs_iou.sv =====
// Four-stage overlap pipeline: tests one kept box against the current box per beat.
// Depends on gbs_pkg for box, entry and status types.
module gbs_iou (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  gbs_pkg::box_type              cur,
   input  logic [gbs_pkg::AREA_W-1:0]    cur_area,
   input  logic [gbs_pkg::THR_W-1:0]     thr,
   input  gbs_pkg::entry_type            kept_entry,
   output gbs_pkg::cmp_type              status
);

   localparam int AW = gbs_pkg::AREA_W;
   localparam int SW = gbs_pkg::SIZE_W;
   localparam int CW = gbs_pkg::COORD_W;

   logic signed [CW:0]   cur_r, cur_b, kb_r, kb_b, x1, y1;
   logic signed [CW-1:0] x0, y0;
   logic signed [CW+1:0] dx, dy;
   logic [SW-1:0]        dx_in, dy_in, dx_ff, dy_ff;
   logic [AW-1:0]        karea_ff;
   logic                 s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [AW-1:0]        inter_in, inter_ff;
   logic [AW:0]          sum_in, sum_ff, uni;
   logic [31:0]          prod_in, prod_ff;
   logic [AW+7:0]        lhs_in, lhs_ff;
   logic                 nz_in, nz_ff, hit_in, hit_ff;

   // stage 1: overlap extents
   always_comb begin
      cur_r = $signed({cur.left[CW-1], cur.left}) + $signed({2'b00, cur.width});
      cur_b = $signed({cur.top[CW-1], cur.top}) + $signed({2'b00, cur.height});
      kb_r  = $signed({kept_entry.box.left[CW-1], kept_entry.box.left})
            + $signed({2'b00, kept_entry.box.width});
      kb_b  = $signed({kept_entry.box.top[CW-1], kept_entry.box.top})
            + $signed({2'b00, kept_entry.box.height});
      x0 = (cur.left > kept_entry.box.left) ? cur.left : kept_entry.box.left;
      y0 = (cur.top > kept_entry.box.top) ? cur.top : kept_entry.box.top;
      x1 = (cur_r < kb_r) ? cur_r : kb_r;
      y1 = (cur_b < kb_b) ? cur_b : kb_b;
      dx = $signed({x1[CW], x1}) - $signed({{2{x0[CW-1]}}, x0});
      dy = $signed({y1[CW], y1}) - $signed({{2{y0[CW-1]}}, y0});
      dx_in = (dx > 14'sd0) ? dx[SW-1:0] : '0;
      dy_in = (dy > 14'sd0) ? dy[SW-1:0] : '0;
   end

   // stage 2: intersection and area sum
   assign inter_in = dx_ff * dy_ff;
   assign sum_in   = {1'b0, cur_area} + {1'b0, karea_ff};

   // stage 3: union and scaled threshold
   assign uni     = sum_ff - {1'b0, inter_ff};
   assign prod_in = {{(32-gbs_pkg::THR_W){1'b0}}, thr} * {{(31-AW){1'b0}}, uni};
   assign lhs_in  = {inter_ff, 8'b0};
   assign nz_in   = (uni != '0);

   // stage 4: compare
   assign hit_in = s3_valid_ff && nz_ff && ({{(32-AW-8){1'b0}}, lhs_ff} > prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         hit_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         hit_ff      <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      karea_ff <= kept_entry.area;
      inter_ff <= inter_in;
      sum_ff   <= sum_in;
      prod_ff  <= prod_in;
      lhs_ff   <= lhs_in;
      nz_ff    <= nz_in;
   end

   assign status.busy = s1_valid_ff | s2_valid_ff | s3_valid_ff | s4_valid_ff;
   assign status.hit  = hit_ff;

endmodule

// ===== rtl/greedy_box_suppression.sv =====
// Greedy box suppression top level: kept-box memory, scan sequencer, result register.
// A new box is accepted only in the idle state, once the previous box has reached its result register.
// The kept memory is read one entry per cycle
// into the four-stage gbs_iou pipeline, which then drains.
// Reset: clears count, set position, sequencer and result valid flag; threshold to 115.
// The kept memory is not cleared; only entries below the count are ever read.
module greedy_box_suppression #(
   parameter int MAX_KEPT  = 64,
   parameter int MAX_BOXES = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   gbs_req_if.sink                     req_ch,
   gbs_rsp_if.source                   rsp_ch,
   input  logic                        csr_wr_en,
   input  logic [gbs_pkg::THR_W-1:0]   csr_wr_data
);

   localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CW = $clog2(MAX_KEPT + 1);
   localparam int IW = gbs_pkg::INDEX_W;
   localparam logic [IW-1:0] POS_LIMIT =
      IW'((MAX_BOXES - 1 < 1023) ? MAX_BOXES - 1 : 1023);
   localparam logic [CW-1:0] KEPT_MAX = CW'(MAX_KEPT);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_AREA  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   gbs_pkg::entry_type mem [MAX_KEPT];
   gbs_pkg::entry_type rd_data_ff;

   logic [2:0]                    state_ff, state_in;
   logic [gbs_pkg::THR_W-1:0]     thr_ff;
   gbs_pkg::box_type              cur_ff;
   logic [gbs_pkg::AREA_W-1:0]    area_ff;
   logic [CW-1:0]                 count_ff, count_in, rd_idx_ff, rd_idx_in;
   logic [IW-1:0]                 pos_ff, pos_in;
   logic                          hit_ff, hit_in, rd_pend_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_kept_ff, rsp_ovf_ff;
   logic [IW-1:0]                 rsp_index_ff;
   logic                          accept, rd_en, done_go, keep, store;
   gbs_pkg::cmp_type              cmp;
   gbs_pkg::entry_type            wr_entry;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rd_en        = (state_ff == ST_SCAN) && (rd_idx_ff < count_ff);
   assign done_go      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);
   assign keep         = !hit_ff;
   assign store        = keep && (count_ff < KEPT_MAX);
   assign wr_entry.box  = cur_ff;
   assign wr_entry.area = area_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      pos_in       = pos_ff;
      hit_in       = hit_ff | cmp.hit;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in  = ST_AREA;
               rd_idx_in = '0;
               hit_in    = 1'b0;
               if (req_ch.first_of_set) begin
                  count_in = '0;
                  pos_in   = '0;
               end
            end
         end
         ST_AREA: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (rd_en) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_pend_ff && !cmp.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_go) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (store) begin
                  count_in = count_ff + 1'b1;
               end
               if (pos_ff < POS_LIMIT) begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= gbs_pkg::THR_RESET;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         pos_ff       <= '0;
         hit_ff       <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         pos_ff       <= pos_in;
         hit_ff       <= hit_in;
         rd_pend_ff   <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff.left   <= req_ch.box_left;
         cur_ff.top    <= req_ch.box_top;
         cur_ff.width  <= req_ch.box_width;
         cur_ff.height <= req_ch.box_height;
      end
      if (state_ff == ST_AREA) begin
         area_ff <= cur_ff.width * cur_ff.height;
      end
      if (done_go) begin
         rsp_kept_ff  <= keep;
         rsp_ovf_ff   <= keep && !store;
         rsp_index_ff <= pos_ff;
      end
   end

   // kept-box memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (done_go && store) begin
         mem[count_ff[AW-1:0]] <= wr_entry;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx_ff[AW-1:0]];
      end
   end

   gbs_iou u_iou (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (rd_pend_ff),
      .cur        (cur_ff),
      .cur_area   (area_ff),
      .thr        (thr_ff),
      .kept_entry (rd_data_ff),
      .status     (cmp)
   );

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.kept           = rsp_kept_ff;
   assign rsp_ch.box_index      = rsp_index_ff;
   assign rsp_ch.store_overflow = rsp_ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= KEPT_MAX)
      else $error("kept count beyond store depth");

   a_ovf_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |-> rsp_kept_ff)
      else $error("overflow flagged on a dropped box");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the finishing step");

   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> !cmp.busy && !rd_pend_ff)
      else $error("verdict taken with compares in flight");

endmodule
